// ===== hdl/fcbe_pkg.sv =====
package fcbe_pkg;

   localparam logic [7:0] QMARK      = 8'h3F;
   localparam logic [7:0] SPACE      = 8'h20;
   localparam logic [7:0] SWITCH_CODE = 8'd30;
   localparam logic [7:0] HIGH_BIT   = 8'h80;
   localparam int         OFFSET     = 14;

   localparam logic OP_TABLE = 1'b0;
   localparam logic OP_PATH  = 1'b1;

   typedef struct packed {
      logic       start;
      logic [7:0] a;
      logic [7:0] b;
   } search_req_type;

   typedef struct packed {
      logic       done;
      logic       found;
      logic [6:0] index;
   } search_rsp_type;

   function automatic logic [7:0] squelch(input logic [7:0] raw);
      logic [7:0] m;
      m = raw[7] ? {1'b0, raw[6:0]} : raw;
      return (m <= SWITCH_CODE) ? QMARK : m;
   endfunction

endpackage

// ===== hdl/fcbe_search.sv =====
module fcbe_search import fcbe_pkg::*; #(
   parameter int BIGRAM_PAIRS = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  logic [7:0]     wr_index,
   input  logic [7:0]     wr_data,
   input  search_req_type req,
   output search_rsp_type rsp
);

   localparam int ENTRIES = 2 * BIGRAM_PAIRS;
   localparam int KW = (BIGRAM_PAIRS > 1) ? $clog2(BIGRAM_PAIRS) : 1;

   // Each pair is stored as one 16-bit word so a single read gives both bytes.
   logic [15:0] pair_mem [BIGRAM_PAIRS];
   logic [BIGRAM_PAIRS-1:0] pair_valid_ff;
   logic [7:0]  wr_index_ok;
   logic [KW-1:0] wr_pair;

   logic        busy_ff, busy_in;
   logic        rd_pend_ff, rd_pend_in;
   logic [KW:0] k_ff, k_in;
   logic [15:0] rd_data_ff;
   logic        rd_valid_ff;
   logic [7:0]  a_ff, b_ff;
   search_rsp_type rsp_in;

   assign wr_index_ok = wr_index;
   assign wr_pair     = wr_index[KW:1];

   always_ff @(posedge clock) begin
      if (wr_en && ({24'd0, wr_index_ok} < ENTRIES)) begin
         if (!pair_valid_ff[wr_pair])
            pair_mem[wr_pair] <= wr_index[0] ? {8'd0, wr_data} : {wr_data, 8'd0};
         else if (wr_index[0])
            pair_mem[wr_pair][7:0] <= wr_data;
         else
            pair_mem[wr_pair][15:8] <= wr_data;
      end
      if (reset)
         pair_valid_ff <= '0;
      else if (wr_en && ({24'd0, wr_index_ok} < ENTRIES))
         pair_valid_ff[wr_pair] <= 1'b1;
   end

   // The first write to a pair clears its other byte; a pair that was never
   // touched reads as zero through its valid bit.
   always_ff @(posedge clock) begin
      rd_data_ff  <= pair_mem[k_ff[KW-1:0]];
      rd_valid_ff <= pair_valid_ff[k_ff[KW-1:0]];
   end

   always_comb begin
      busy_in    = busy_ff;
      rd_pend_in = 1'b0;
      k_in       = k_ff;
      rsp_in     = '0;
      if (req.start) begin
         busy_in    = 1'b1;
         k_in       = '0;
         rd_pend_in = 1'b1;
      end else if (busy_ff) begin
         if (rd_pend_ff) begin
            rd_pend_in = 1'b0;
         end else begin
            priority if (!rd_valid_ff || rd_data_ff[15:8] == 8'd0) begin
               busy_in = 1'b0;
               rsp_in.done = 1'b1;
            end else if (rd_data_ff == {a_ff, b_ff}) begin
               busy_in = 1'b0;
               rsp_in.done = 1'b1;
               rsp_in.found = 1'b1;
               rsp_in.index = 7'(k_ff);
            end else if (k_ff == (KW+1)'(BIGRAM_PAIRS - 1)) begin
               busy_in = 1'b0;
               rsp_in.done = 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff <= req.a;
         b_ff <= req.b;
      end
      if (reset) begin
         busy_ff    <= 1'b0;
         rd_pend_ff <= 1'b0;
         k_ff       <= '0;
         rsp        <= '0;
      end else begin
         busy_ff    <= busy_in;
         rd_pend_ff <= rd_pend_in;
         k_ff       <= k_in;
         rsp        <= rsp_in;
      end
   end

endmodule

// ===== hdl/front_compress_bigram_encoder.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  op, data_byte, table_index, end_of_path
// rsp_      out        rsp_valid/rsp_stall  out_byte, last_of_run, path_done
// A table load passes through S_TABLE. A path byte passes through S_READ,
// S_DECIDE and S_WAIT, then S_EMIT if it has result bytes; a residue pair
// adds S_SEARCH, where the single comparator examines bigram pairs in turn.
// Reset is synchronous; the previous-path memory is tracked by a fill count,
// so no clearing pass is needed. A stalled result holds the sequencer.
module front_compress_bigram_encoder import fcbe_pkg::*; #(
   parameter int MAX_PATH     = 1024,
   parameter int BIGRAM_PAIRS = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_table_index,
   input  logic       req_end_of_path,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_path_done
);

   localparam int PW = $clog2(MAX_PATH + 1) + 1;
   localparam int AW = $clog2(MAX_PATH + 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_READ   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_SEARCH = 7'b0001000,
      S_EMIT   = 7'b0010000,
      S_TABLE  = 7'b0100000,
      S_WAIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] prev_mem [MAX_PATH + 1];
   logic [7:0] rd_ff;
   logic [PW-1:0] fill_ff, fill_in;   // entries below this index are valid
   logic [PW-1:0] wpos_ff, wpos_in, ppl_ff, ppl_in;
   logic match_ff, match_in, held_v_ff, held_v_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] b_ff;
   logic       last_ff;
   // Position 0 holds the initial space until it is first written.
   logic       pos0_written_ff, pos0_written_in;

   // Result queue of up to seven bytes.
   logic [7:0] q_ff [7], q_in [7];
   logic [2:0] qn_ff, qn_in, qi_ff, qi_in;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   search_req_type sreq;
   search_rsp_type srsp;

   fcbe_search #(.BIGRAM_PAIRS(BIGRAM_PAIRS)) u_search (
      .clock(clock), .reset(reset),
      .wr_en(state_ff == S_IDLE && req_valid && req_op == OP_TABLE),
      .wr_index(req_table_index), .wr_data(req_data_byte),
      .req(sreq), .rsp(srsp)
   );

   assign req_stall = (state_ff != S_IDLE);

   logic [7:0] prev_byte;
   assign prev_byte = (wpos_ff == '0 && !pos0_written_ff) ? SPACE :
                      (wpos_ff < fill_ff) ? rd_ff : 8'd0;

   assign pos0_written_in = pos0_written_ff | (mem_we && mem_wa == '0);

   always_ff @(posedge clock) begin
      if (mem_we) prev_mem[mem_wa] <= mem_wd;
      rd_ff <= prev_mem[wpos_ff[AW-1:0]];
   end

   always_comb begin
      logic [PW-1:0] cnt;
      logic [31:0]   d;
      logic [2:0]    n;
      logic          ok;
      state_in  = state_ff;
      fill_in   = fill_ff;
      wpos_in   = wpos_ff;
      ppl_in    = ppl_ff;
      match_in  = match_ff;
      held_v_in = held_v_ff;
      held_in   = held_ff;
      q_in      = q_ff;
      qn_in     = qn_ff;
      qi_in     = qi_ff;
      mem_we    = 1'b0;
      mem_wa    = wpos_ff[AW-1:0];
      mem_wd    = b_ff;
      sreq      = '0;
      cnt       = '0;
      d         = '0;
      n         = qn_ff;
      ok        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               qn_in = '0;
               qi_in = '0;
               state_in = (req_op == OP_TABLE) ? S_TABLE : S_READ;
            end
         end
         S_TABLE: state_in = S_IDLE;
         S_READ: state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_WAIT;
            if (wpos_ff < PW'(MAX_PATH)) begin
               wpos_in = wpos_ff + 1'b1;
               if (!(match_ff && prev_byte == b_ff)) begin
                  mem_we = 1'b1;
                  if (wpos_ff >= fill_ff) fill_in = wpos_ff + 1'b1;
                  if (match_ff) begin
                     match_in = 1'b0;
                     cnt = wpos_ff;
                     ok = 1'b1;
                     held_in = b_ff;
                     held_v_in = 1'b1;
                  end else if (held_v_ff) begin
                     sreq.start = 1'b1;
                     sreq.a = held_ff;
                     sreq.b = b_ff;
                     held_v_in = 1'b0;
                     state_in = S_SEARCH;
                  end else begin
                     held_in = b_ff;
                     held_v_in = 1'b1;
                  end
               end
            end
            if (ok) begin
               d = 32'(cnt) + 32'(OFFSET) - 32'(ppl_ff);
               if (32'(cnt) + 32'(OFFSET) >= 32'(ppl_ff) && d <= 32'(2 * OFFSET)) begin
                  q_in[0] = d[7:0];
                  qn_in = 3'd1;
               end else begin
                  q_in[0] = SWITCH_CODE;
                  q_in[1] = d[7:0];
                  q_in[2] = d[15:8];
                  q_in[3] = d[23:16];
                  q_in[4] = d[31:24];
                  qn_in = 3'd5;
               end
               ppl_in = cnt;
            end
         end
         S_SEARCH: begin
            if (srsp.done) begin
               if (srsp.found) begin
                  q_in[qn_ff] = HIGH_BIT | {1'b0, srsp.index};
                  qn_in = qn_ff + 3'd1;
               end else begin
                  q_in[qn_ff] = held_ff;
                  q_in[qn_ff + 3'd1] = b_ff;
                  qn_in = qn_ff + 3'd2;
               end
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // End-of-path handling once the byte's own results are queued.
            if (last_ff) begin
               if (match_ff) begin
                  d = 32'(wpos_ff) + 32'(OFFSET) - 32'(ppl_ff);
                  if (32'(wpos_ff) + 32'(OFFSET) >= 32'(ppl_ff) &&
                      d <= 32'(2 * OFFSET)) begin
                     q_in[n] = d[7:0];
                     n = n + 3'd1;
                  end else begin
                     q_in[n] = SWITCH_CODE;
                     q_in[n + 3'd1] = d[7:0];
                     q_in[n + 3'd2] = d[15:8];
                     q_in[n + 3'd3] = d[23:16];
                     q_in[n + 3'd4] = d[31:24];
                     n = n + 3'd5;
                  end
                  ppl_in = wpos_ff;
               end else if (held_v_ff) begin
                  q_in[n] = held_ff;
                  n = n + 3'd1;
               end
               qn_in = n;
               if (wpos_ff <= PW'(MAX_PATH)) begin
                  mem_we = 1'b1;
                  mem_wd = 8'd0;
                  if (wpos_ff >= fill_ff) fill_in = wpos_ff + 1'b1;
               end
               wpos_in = '0;
               match_in = 1'b1;
               held_v_in = 1'b0;
               held_in = 8'd0;
            end
            state_in = (n == 3'd0) ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               qi_in = qi_ff + 3'd1;
               if (qi_ff + 3'd1 == qn_ff) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_out_byte    = q_ff[qi_ff];
   assign rsp_last_of_run = (qi_ff + 3'd1 == qn_ff);
   assign rsp_path_done   = last_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         b_ff    <= squelch(req_data_byte);
         last_ff <= req_end_of_path;
      end
      q_ff <= q_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= PW'(1);
         wpos_ff   <= '0;
         ppl_ff    <= '0;
         match_ff  <= 1'b1;
         held_v_ff <= 1'b0;
         held_ff   <= 8'd0;
         qn_ff     <= '0;
         qi_ff     <= '0;
         pos0_written_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         wpos_ff   <= wpos_in;
         ppl_ff    <= ppl_in;
         match_ff  <= match_in;
         held_v_ff <= held_v_in;
         held_ff   <= held_in;
         qn_ff     <= qn_in;
         qi_ff     <= qi_in;
         pos0_written_ff <= pos0_written_in;
      end
   end

endmodule
